@@ src/stereo_to_surround_biquad_upmixer_defines.svh @@
// Assertion macros for the stereo to surround upmixer.
// Used by the top level only; expects a clock named clk and a reset named rst.
`ifndef STEREO_TO_SURROUND_BIQUAD_UPMIXER_DEFINES_SVH
`define STEREO_TO_SURROUND_BIQUAD_UPMIXER_DEFINES_SVH

// Same-cycle implication
`define STSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define STSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication after a fixed number of cycles
`define STSU_ASSERT_AFTER(label, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

@@ src/stsu_pkg.sv @@
// Shared types, constants and coefficient table for the stereo to surround upmixer.
// No dependencies; imported by every module of the block.
package stsu_pkg;

  // Defaults for the top-level parameters
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEF_FRAC_DEF    = 30;

  // Fixed datapath widths
  localparam int GAIN_W   = 5;
  localparam int Y_W      = 40;               // filter output history, Q31.8
  localparam int Y_FRAC   = 8;
  localparam int OP_W     = 40;               // multiplier operand (x or y history)
  localparam int OP_HALF  = 20;               // operand split point
  localparam int COEF_W   = 32;
  localparam int TERM_W   = COEF_W + OP_W;    // one full product
  localparam int ACC_W    = TERM_W + Y_FRAC + 3;
  localparam int NUM_SLOT = 6;
  localparam int SLOT_W   = 3;

  // Configuration register indexes and reset values
  localparam logic REG_ROUTING_MODE = 1'b0;
  localparam logic REG_INPUT_GAIN   = 1'b1;
  localparam logic ROUTE_SPLIT      = 1'b0;
  localparam logic ROUTE_PASS_LEFT  = 1'b1;
  localparam logic MODE_RESET       = ROUTE_PASS_LEFT;
  localparam logic signed [GAIN_W-1:0] GAIN_RESET = -5'sd3;

  // Biquad term order within one filter
  localparam logic [2:0] TERM_X0 = 3'd0;
  localparam logic [2:0] TERM_X1 = 3'd1;
  localparam logic [2:0] TERM_X2 = 3'd2;
  localparam logic [2:0] TERM_Y1 = 3'd3;
  localparam logic [2:0] TERM_Y2 = 3'd4;

  // Index of the last biquad per routing mode
  localparam logic [2:0] BQ_LAST_SPLIT = 3'd5;
  localparam logic [2:0] BQ_LAST_PASS  = 3'd4;

  typedef enum logic [1:0] {
    FILT_LP,
    FILT_HP,
    FILT_BP
  } filt_t;

  typedef enum logic [SLOT_W-1:0] {
    SLOT_L,
    SLOT_C,
    SLOT_R,
    SLOT_LS,
    SLOT_RS,
    SLOT_LFE
  } slot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_XFER
  } state_t;

  typedef struct packed {
    slot_t slot;
    filt_t filt;
    logic  src_right;
  } route_t;

  // Control that travels with each product through the MAC pipeline
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic bterm;   // feed-forward term: scaled by 2^8, added; else subtracted
  } mac_ctl_t;

  // Q2.30 coefficients: b0, b1, b2, a1, a2
  function automatic logic signed [COEF_W:0] coef_q30(filt_t f, logic [2:0] k);
    logic signed [COEF_W:0] c;
    c = '0;
    unique case (f)
      FILT_LP: begin
        unique case (k)
          TERM_X0: c = 33'sd610995363;
          TERM_X1: c = 33'sd1221990726;
          TERM_X2: c = 33'sd610995363;
          TERM_Y1: c = 33'sd1012330264;
          TERM_Y2: c = 33'sd357909365;
          default: c = '0;
        endcase
      end
      FILT_HP: begin
        unique case (k)
          TERM_X0: c = 33'sd997101531;
          TERM_X1: c = -33'sd1994203062;
          TERM_X2: c = 33'sd997101531;
          TERM_Y1: c = -33'sd1988725833;
          TERM_Y2: c = 33'sd925938467;
          default: c = '0;
        endcase
      end
      FILT_BP: begin
        unique case (k)
          TERM_X0: c = 33'sd399719220;
          TERM_X1: c = '0;
          TERM_X2: c = -33'sd399719220;
          TERM_Y1: c = -33'sd734198042;
          TERM_Y2: c = 33'sd274303385;
          default: c = '0;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  // Coefficient rounded half up to frac fraction bits
  function automatic logic signed [COEF_W-1:0] coef_val(filt_t f, logic [2:0] k, int frac);
    logic signed [COEF_W:0] q;
    logic signed [COEF_W:0] half;
    logic signed [COEF_W:0] r;
    int sh;
    q    = coef_q30(f, k);
    sh   = 30 - frac;
    half = (sh == 0) ? '0 : (33'sd1 <<< (sh - 1));
    r    = (q + half) >>> sh;
    return r[COEF_W-1:0];
  endfunction

  // Which slot, filter and source each biquad step serves
  function automatic route_t route_of(logic mode, logic [2:0] j);
    route_t r;
    r = '{slot: SLOT_L, filt: FILT_LP, src_right: 1'b0};
    if (mode == ROUTE_SPLIT) begin
      unique case (j)
        3'd0: r = '{slot: SLOT_L,   filt: FILT_LP, src_right: 1'b0};
        3'd1: r = '{slot: SLOT_C,   filt: FILT_HP, src_right: 1'b0};
        3'd2: r = '{slot: SLOT_LS,  filt: FILT_BP, src_right: 1'b0};
        3'd3: r = '{slot: SLOT_RS,  filt: FILT_BP, src_right: 1'b1};
        3'd4: r = '{slot: SLOT_R,   filt: FILT_HP, src_right: 1'b1};
        3'd5: r = '{slot: SLOT_LFE, filt: FILT_LP, src_right: 1'b1};
        default: r = '{slot: SLOT_L, filt: FILT_LP, src_right: 1'b0};
      endcase
    end else begin
      unique case (j)
        3'd0: r = '{slot: SLOT_C,   filt: FILT_LP, src_right: 1'b0};
        3'd1: r = '{slot: SLOT_LS,  filt: FILT_HP, src_right: 1'b0};
        3'd2: r = '{slot: SLOT_RS,  filt: FILT_BP, src_right: 1'b0};
        3'd3: r = '{slot: SLOT_R,   filt: FILT_BP, src_right: 1'b1};
        3'd4: r = '{slot: SLOT_LFE, filt: FILT_HP, src_right: 1'b1};
        default: r = '{slot: SLOT_C, filt: FILT_LP, src_right: 1'b0};
      endcase
    end
    return r;
  endfunction

endpackage

@@ src/stsu_hist_mem.sv @@
// Filter history memory: one row per output slot holding x1, x2, y1, y2.
// Depends on stsu_pkg. Registered read; rows never written read as zero.
module stsu_hist_mem
  import stsu_pkg::*;
#(
  parameter int ROW_W = 2 * (SAMPLE_WIDTH_DEF + GAIN_W) + 2 * Y_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_addr,
  input  logic [ROW_W-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output logic [ROW_W-1:0]  rd_data
);

  logic [ROW_W-1:0]    mem [NUM_SLOT];
  logic [NUM_SLOT-1:0] row_vld;
  logic [ROW_W-1:0]    rd_q;
  logic                rd_vld;

  // Storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Per-row valid bits stand in for the all-zero reset state
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= row_vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

@@ src/stsu_mac.sv @@
// Shared pipelined multiply-accumulate unit for the biquad products.
// Depends on stsu_pkg. Stages: split multiply, recombine, accumulate, scale and clamp.
module stsu_mac
  import stsu_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctl_t                 ctl,
  input  logic signed [COEF_W-1:0] coef,
  input  logic signed [OP_W-1:0]   opnd,
  output logic                     y_vld,
  output logic signed [Y_W-1:0]    y
);

  localparam int PL_W = COEF_W + OP_HALF + 1;
  localparam int PH_W = COEF_W + OP_W - OP_HALF;

  mac_ctl_t ctl_a;
  mac_ctl_t ctl_b;
  logic     acc_done;

  logic signed [COEF_W+OP_HALF:0]        p_lo;
  logic signed [COEF_W+OP_W-OP_HALF-1:0] p_hi;
  logic signed [TERM_W-1:0]              sum;
  logic signed [ACC_W-1:0]               acc;

  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] scaled;
  logic                    ovf;

  // Control pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a    <= '0;
      ctl_b    <= '0;
      acc_done <= 1'b0;
      y_vld    <= 1'b0;
    end else begin
      ctl_a    <= ctl;
      ctl_b    <= ctl_a;
      acc_done <= ctl_b.vld && ctl_b.last;
      y_vld    <= acc_done;
    end
  end

  // Stage A: operand split in two halves, two narrow multiplies
  always_ff @(posedge clk) begin
    p_lo <= PL_W'(coef) * PL_W'($signed({1'b0, opnd[OP_HALF-1:0]}));
    p_hi <= PH_W'(coef) * PH_W'($signed(opnd[OP_W-1:OP_HALF]));
  end

  // Stage B: recombine into the full product
  always_ff @(posedge clk) begin
    sum <= (TERM_W'(p_hi) <<< OP_HALF) + TERM_W'(p_lo);
  end

  // Stage C: accumulate; feed-forward terms carry the 2^8 output scale
  always_comb begin
    term = ACC_W'(sum);
    if (ctl_b.bterm) begin
      term = term <<< Y_FRAC;
    end
    base = ctl_b.first ? '0 : acc;
  end

  always_ff @(posedge clk) begin
    if (ctl_b.vld) begin
      acc <= ctl_b.bterm ? (base + term) : (base - term);
    end
  end

  // Stage D: floor to 8 fraction bits, clamp to the history width
  always_comb begin
    scaled = acc >>> COEF_FRAC_BITS;
    ovf    = !((&scaled[ACC_W-1:Y_W-1]) || !(|scaled[ACC_W-1:Y_W-1]));
  end

  always_ff @(posedge clk) begin
    if (acc_done) begin
      if (ovf) begin
        y <= {scaled[ACC_W-1], {(Y_W-1){~scaled[ACC_W-1]}}};
      end else begin
        y <= scaled[Y_W-1:0];
      end
    end
  end

endmodule

@@ src/stereo_to_surround_biquad_upmixer.sv @@
// Stereo to 5.1 upmixer top level: control sequencer, gain, routing and output registers.
// Depends on stsu_pkg, stsu_hist_mem, stsu_mac and the assertion macro header.
//
// Usage:
//   Input channel in_valid/in_ready carries one stereo frame (left_sample,
//   right_sample); a transfer happens when both are high. Output channel
//   out_valid/out_ready carries six saturated channel samples per frame.
//   Config port: cfg_we writes cfg_data to register cfg_index (0 routing_mode,
//   1 input_gain) at the clock edge; write only while the block is idle.
// Timing:
//   One multiply-accumulate unit computes all biquad products, one product per
//   cycle, five per filter. Routing mode 0 runs six filters, mode 1 runs five.
//   A frame passes through its 30 or 25 products, the MAC pipeline, the
//   handoff state and the idle state that takes the next frame.
//   in_ready is high only while no frame is in progress.
// Reset: synchronous rst clears all filter histories, sets routing_mode to 1
//   and input_gain to -3, and empties the output register.
// Stall: a finished frame waits in the output register while out_ready is low;
//   a new frame may be taken and computed meanwhile, and it waits for the
//   output register before handoff.
`include "stereo_to_surround_biquad_upmixer_defines.svh"

module stereo_to_surround_biquad_upmixer
  import stsu_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [GAIN_W-1:0]              cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] left_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] right_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_left,
  output logic signed [SAMPLE_WIDTH-1:0] out_center,
  output logic signed [SAMPLE_WIDTH-1:0] out_right,
  output logic signed [SAMPLE_WIDTH-1:0] out_left_surround,
  output logic signed [SAMPLE_WIDTH-1:0] out_right_surround,
  output logic signed [SAMPLE_WIDTH-1:0] out_lfe
);

  localparam int X_W   = SAMPLE_WIDTH + GAIN_W;
  localparam int ROW_W = 2 * X_W + 2 * Y_W;

  // Configuration registers
  logic                     routing_mode;
  logic signed [GAIN_W-1:0] input_gain;

  // Sequencer
  state_t     state;
  state_t     state_next;
  logic [2:0] j;
  logic [2:0] k;
  logic [2:0] j_last;
  route_t     rt_cur;
  route_t     rt_nxt;
  logic       issue;
  logic       load_out;

  // Gained samples of the frame in progress
  logic signed [X_W-1:0] gl;
  logic signed [X_W-1:0] gr;
  logic signed [X_W-1:0] xl;
  logic signed [X_W-1:0] xr;
  logic signed [X_W-1:0] x_cur;

  // History memory port signals
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  wb_row;
  logic signed [X_W-1:0] row_x1;
  logic signed [X_W-1:0] row_x2;
  logic signed [Y_W-1:0] row_y1;
  logic signed [Y_W-1:0] row_y2;

  // MAC interface
  mac_ctl_t                 mac_ctl;
  logic signed [COEF_W-1:0] mac_coef;
  logic signed [OP_W-1:0]   mac_opnd;
  logic                     wb_vld;
  logic signed [Y_W-1:0]    wb_y;

  // Values held for the write-back of the filter just issued
  logic signed [X_W-1:0] hx;
  logic signed [X_W-1:0] hx1;
  logic signed [Y_W-1:0] hy1;
  slot_t                 hslot;
  logic                  hfinal;

  // Per-slot results of the frame in progress
  logic signed [SAMPLE_WIDTH-1:0] ch_res [NUM_SLOT];
  logic signed [SAMPLE_WIDTH-1:0] wb_out;
  logic signed [SAMPLE_WIDTH-1:0] pass_l;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      routing_mode <= MODE_RESET;
      input_gain   <= GAIN_RESET;
    end else if (cfg_we) begin
      priority case (cfg_index)
        REG_ROUTING_MODE: routing_mode <= cfg_data[0];
        REG_INPUT_GAIN:   input_gain   <= cfg_data;
        default:          routing_mode <= routing_mode;
      endcase
    end
  end

  // Gain, applied as the frame is taken
  assign gl = X_W'(left_sample) * X_W'(input_gain);
  assign gr = X_W'(right_sample) * X_W'(input_gain);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      xl <= gl;
      xr <= gr;
    end
  end

  // Routing lookups for the current and the next biquad
  always_comb begin
    j_last = (routing_mode == ROUTE_SPLIT) ? BQ_LAST_SPLIT : BQ_LAST_PASS;
    rt_cur = route_of(routing_mode, j);
    rt_nxt = route_of(routing_mode, (state == ST_IDLE) ? 3'd0 : (j + 3'd1));
    x_cur  = rt_cur.src_right ? xr : xl;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (k == TERM_Y2 && j == j_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (wb_vld && hfinal) begin
          state_next = ST_XFER;
        end
      end
      ST_XFER: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    rd_en    = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        rd_en    = in_valid;
      end
      ST_RUN: begin
        issue = 1'b1;
        rd_en = (k == TERM_Y2) && (j != j_last);
      end
      ST_DRAIN: begin
        issue = 1'b0;
      end
      ST_XFER: begin
        load_out = !out_valid || out_ready;
      end
      default: in_ready = 1'b0;
    endcase
  end

  assign rd_addr = rt_nxt.slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      j     <= '0;
      k     <= TERM_X0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        j <= '0;
        k <= TERM_X0;
      end else if (issue) begin
        if (k == TERM_Y2) begin
          k <= TERM_X0;
          j <= j + 3'd1;
        end else begin
          k <= k + 3'd1;
        end
      end
    end
  end

  // History row fields: {y2, y1, x2, x1}
  assign row_x1 = row[X_W-1:0];
  assign row_x2 = row[2*X_W-1:X_W];
  assign row_y1 = row[2*X_W+Y_W-1:2*X_W];
  assign row_y2 = row[ROW_W-1:2*X_W+Y_W];

  // Product issue: one term per cycle
  always_comb begin
    mac_ctl.vld   = issue;
    mac_ctl.first = (k == TERM_X0);
    mac_ctl.last  = (k == TERM_Y2);
    mac_ctl.bterm = (k == TERM_X0) || (k == TERM_X1) || (k == TERM_X2);
    mac_coef      = coef_val(rt_cur.filt, k, COEF_FRAC_BITS);
    unique case (k)
      TERM_X0: mac_opnd = {{(OP_W-X_W){x_cur[X_W-1]}}, x_cur};
      TERM_X1: mac_opnd = {{(OP_W-X_W){row_x1[X_W-1]}}, row_x1};
      TERM_X2: mac_opnd = {{(OP_W-X_W){row_x2[X_W-1]}}, row_x2};
      TERM_Y1: mac_opnd = row_y1;
      TERM_Y2: mac_opnd = row_y2;
      default: mac_opnd = '0;
    endcase
  end

  // Hold write-back values; the next read lands only after the last issue
  always_ff @(posedge clk) begin
    if (issue && k == TERM_Y2) begin
      hx     <= x_cur;
      hx1    <= row_x1;
      hy1    <= row_y1;
      hslot  <= rt_cur.slot;
      hfinal <= (j == j_last);
    end
  end

  stsu_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mac_ctl),
    .coef  (mac_coef),
    .opnd  (mac_opnd),
    .y_vld (wb_vld),
    .y     (wb_y)
  );

  // Slots are distinct within a frame, so a row is never read while its write is pending
  assign wb_row = {hy1, wb_y, hx1, hx};

  stsu_hist_mem #(
    .ROW_W (ROW_W)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wb_vld),
    .wr_addr (hslot),
    .wr_data (wb_row),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (row)
  );

  // Sample-range saturation of the filter output and of the gain-only path
  always_comb begin
    if ((&wb_y[Y_W-1:SAMPLE_WIDTH+Y_FRAC-1]) || !(|wb_y[Y_W-1:SAMPLE_WIDTH+Y_FRAC-1])) begin
      wb_out = wb_y[SAMPLE_WIDTH+Y_FRAC-1:Y_FRAC];
    end else begin
      wb_out = {wb_y[Y_W-1], {(SAMPLE_WIDTH-1){~wb_y[Y_W-1]}}};
    end
    if ((&xl[X_W-1:SAMPLE_WIDTH-1]) || !(|xl[X_W-1:SAMPLE_WIDTH-1])) begin
      pass_l = xl[SAMPLE_WIDTH-1:0];
    end else begin
      pass_l = {xl[X_W-1], {(SAMPLE_WIDTH-1){~xl[X_W-1]}}};
    end
  end

  always_ff @(posedge clk) begin
    if (wb_vld) begin
      ch_res[hslot] <= wb_out;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_left           <= (routing_mode == ROUTE_PASS_LEFT) ? pass_l : ch_res[SLOT_L];
      out_center         <= ch_res[SLOT_C];
      out_right          <= ch_res[SLOT_R];
      out_left_surround  <= ch_res[SLOT_LS];
      out_right_surround <= ch_res[SLOT_RS];
      out_lfe            <= ch_res[SLOT_LFE];
    end
  end

  // Checks
  `STSU_ASSERT_NOW(a_wb_in_frame, wb_vld, (state == ST_RUN) || (state == ST_DRAIN), "history write-back outside a frame")
  `STSU_ASSERT_AFTER(a_mac_latency, issue && (k == TERM_Y2), 4, wb_vld, "filter result missing four cycles after its last product")
  `STSU_ASSERT_NEXT(a_load_valid, load_out, out_valid, "output register load did not raise out_valid")

endmodule
